// ===== sv/pei_pkg.sv =====
// shared types, codes and constants of the damped particle integrator
package pei_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VEC_W     = 32;
  localparam int MUL_W     = 33;
  localparam int PROD_W    = 2 * MUL_W;
  localparam int EXP_STEPS = 16;

  typedef enum logic [2:0] {
    OP_ADD_FORCE = 3'd0,
    OP_INTEGRATE = 3'd1,
    OP_CLR_FORCE = 3'd2,
    OP_LOAD_POS  = 3'd3,
    OP_LOAD_VEL  = 3'd4
  } opcode_t;

  typedef enum logic [7:0] {
    REG_INV_MASS = 8'd0,
    REG_DAMPING  = 8'd1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LOG, S_LT, S_EXP, S_POS, S_ACC, S_VEL, S_DMP, S_DONE
  } state_t;

  typedef logic [29:0] ctab_t [EXP_STEPS];

  // c_k = floor(sqrt(c_(k-1) * 2^30)), c_0 = 2^29, entry j holds c_(j+1)
  function automatic ctab_t build_ctab();
    ctab_t tab;
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] t;
    c = 64'd1 << 29;
    for (int k = 0; k < EXP_STEPS; k++) begin
      v = c << 30;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      c = r;
      tab[k] = c[29:0];
    end
    return tab;
  endfunction

  localparam ctab_t C_TAB = build_ctab();

endpackage

// ===== sv/pei_mul.sv =====
// shared signed multiplier with registered product
module pei_mul import pei_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p
);

  logic signed [PROD_W-1:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= PROD_W'(a) * PROD_W'(b);
  end

  assign p = p_r;

endmodule

// ===== sv/particle_euler_integrator.sv =====
// top level: particle state, sequencer and damping power over one shared multiplier
// load, add force and clear forces pass from idle through the done state to the output register
// integrate: each product goes through the one multiplier; 16 log steps, one
//   scale, 16 exp steps and 12 vector products (the log, scale and exp steps are
//   skipped when the damping factor is trivially one or zero)
// one request at a time; a new request is taken as soon as the sequencer is idle
// rst_n (synchronous): state vectors cleared, inverse mass and damping set to one
module particle_euler_integrator import pei_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // vec_x, vec_y, vec_z, step_time, zero pad
  input  logic [2:0]   in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [287:0] out_tdata,  // pos_x..z, vel_x..z, acc_x..z
  output logic [0:0]   out_tuser,  // saturated
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  state_t state_r, state_nxt;
  logic phase_r;
  logic [3:0] k_r;
  logic signed [VEC_W-1:0] pos_r [3];
  logic signed [VEC_W-1:0] vel_r [3];
  logic signed [VEC_W-1:0] acc_r [3];
  logic signed [VEC_W-1:0] frc_r [3];
  logic [30:0] im_r;
  logic [16:0] damp_r;
  logic [30:0] t_r;
  logic [30:0] m_r;
  logic [15:0] f_r;
  logic [3:0]  n_r;
  logic [35:0] e_r;
  logic [4:0]  ip_r;
  logic [30:0] r_r;
  logic [16:0] fac_r;
  logic        sat_r;
  logic        out_valid_r;
  logic [287:0] out_data_r;
  logic         out_sat_r;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic [1:0] vi;
  logic last_step, accept;
  opcode_t op;
  logic signed [VEC_W-1:0] in_vec [3];
  logic [30:0] in_t;
  logic [16:0] dcl;
  logic [3:0]  n_in;
  logic        fac_one, fac_zero;
  logic [20:0] l_val;
  logic [31:0] m_sq;
  logic [35:0] e_new;
  logic [30:0] r_new;
  logic [30:0] r_sh;
  logic [31:0] fac_sum;

  pei_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(prod));

  // round to nearest, ties up, then clip to 32 bits; msb is the clip flag
  function automatic logic [VEC_W:0] rnd_sat(logic signed [PROD_W-1:0] p, int s);
    logic signed [PROD_W-1:0] q;
    q = (p + (PROD_W'(1) <<< (s - 1))) >>> s;
    if (q > PROD_W'(64'sh7FFF_FFFF)) return {1'b1, 32'h7FFF_FFFF};
    if (q < -PROD_W'(64'sh8000_0000)) return {1'b1, 32'h8000_0000};
    return {1'b0, q[VEC_W-1:0]};
  endfunction

  function automatic logic [VEC_W:0] add_sat(logic signed [VEC_W-1:0] a,
                                             logic signed [VEC_W-1:0] b);
    logic signed [VEC_W:0] s;
    s = {a[VEC_W-1], a} + {b[VEC_W-1], b};
    if (s[VEC_W] != s[VEC_W-1]) return {1'b1, s[VEC_W], {(VEC_W-1){~s[VEC_W]}}};
    return {1'b0, s[VEC_W-1:0]};
  endfunction

  assign vi        = k_r[1:0];
  assign accept    = in_tvalid && in_tready;
  assign op        = opcode_t'(in_tuser);
  assign in_vec[0] = in_tdata[31:0];
  assign in_vec[1] = in_tdata[63:32];
  assign in_vec[2] = in_tdata[95:64];
  assign in_t      = in_tdata[126:96];
  assign cfg_ready = 1'b1;

  // damping power setup
  always_comb begin
    dcl = (damp_r > 17'd65536) ? 17'd65536 : damp_r;
    n_in = '0;
    for (int j = 0; j < 16; j++) begin
      if (dcl[j]) n_in = 4'(j);
    end
    fac_one  = (in_t == '0) || (dcl == 17'd65536);
    fac_zero = (dcl == '0);
  end

  assign l_val   = {5'(5'd16 - {1'b0, n_r}), 16'b0} - {5'b0, f_r};
  assign m_sq    = prod[61:30];
  assign e_new   = prod[FRAC_BITS+35:FRAC_BITS];
  assign r_new   = e_r[4'd15 - k_r] ? prod[60:30] : r_r;
  assign r_sh    = r_new >> ip_r;
  assign fac_sum = 32'(r_sh) + 32'd8192;

  always_comb begin
    last_step = 1'b0;
    unique case (state_r)
      S_LOG, S_EXP:                last_step = phase_r && (k_r == 4'd15);
      S_LT:                        last_step = phase_r;
      S_POS, S_ACC, S_VEL, S_DMP:  last_step = phase_r && (k_r == 4'd2);
      default:                     last_step = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (op == OP_INTEGRATE) state_nxt = (fac_one || fac_zero) ? S_POS : S_LOG;
          else state_nxt = S_DONE;
        end
      end
      S_LOG: if (last_step) state_nxt = S_LT;
      S_LT:  if (last_step) state_nxt = (e_new[35:16] > 20'd30) ? S_POS : S_EXP;
      S_EXP: if (last_step) state_nxt = S_POS;
      S_POS: if (last_step) state_nxt = S_ACC;
      S_ACC: if (last_step) state_nxt = S_VEL;
      S_VEL: if (last_step) state_nxt = S_DMP;
      S_DMP: if (last_step) state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs: handshake and multiplier operands
  always_comb begin
    in_tready = (state_r == S_IDLE);
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_LOG: begin mul_a = MUL_W'(m_r);         mul_b = MUL_W'(m_r); end
      S_LT:  begin mul_a = MUL_W'(l_val);       mul_b = MUL_W'(t_r); end
      S_EXP: begin mul_a = MUL_W'(r_r);         mul_b = MUL_W'(C_TAB[k_r]); end
      S_POS: begin mul_a = MUL_W'(vel_r[vi]);   mul_b = MUL_W'(t_r); end
      S_ACC: begin mul_a = MUL_W'(frc_r[vi]);   mul_b = MUL_W'(im_r); end
      S_VEL: begin mul_a = MUL_W'(acc_r[vi]);   mul_b = MUL_W'(t_r); end
      S_DMP: begin mul_a = MUL_W'(vel_r[vi]);   mul_b = MUL_W'(fac_r); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_a = (state_r == S_POS || state_r == S_VEL || state_r == S_ACC ||
             state_r == S_DMP) ? {mul_a[VEC_W-1], mul_a[VEC_W-1:0]} : mul_a;
  end

  always_ff @(posedge clk) begin
    logic [VEC_W:0] rs;
    logic [VEC_W:0] as;
    logic           sat_v;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
      sat_r       <= 1'b0;
      im_r        <= 31'd65536;
      damp_r      <= 17'd65536;
      for (int j = 0; j < 3; j++) begin
        pos_r[j] <= '0;
        vel_r[j] <= '0;
        acc_r[j] <= '0;
        frc_r[j] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_INV_MASS) im_r <= cfg_data[30:0];
        else if (cfg_index == REG_DAMPING) damp_r <= cfg_data[16:0];
      end

      if (state_r == S_IDLE || state_r == S_DONE) begin
        phase_r <= 1'b0;
        k_r     <= '0;
      end else begin
        phase_r <= ~phase_r;
        if (phase_r) k_r <= (state_nxt != state_r) ? 4'd0 : k_r + 4'd1;
      end

      if (accept) begin
        sat_v = 1'b0;
        t_r   <= in_t;
        n_r   <= n_in;
        m_r   <= 31'(dcl) << (5'd30 - {1'b0, n_in});
        f_r   <= '0;
        r_r   <= 31'd1 << 30;
        fac_r <= fac_one ? 17'd65536 : '0;
        unique case (op)
          OP_ADD_FORCE: begin
            for (int j = 0; j < 3; j++) begin
              as = add_sat(frc_r[j], in_vec[j]);
              frc_r[j] <= as[VEC_W-1:0];
              if (as[VEC_W]) sat_v = 1'b1;
            end
          end
          OP_CLR_FORCE: for (int j = 0; j < 3; j++) frc_r[j] <= '0;
          OP_LOAD_POS:  for (int j = 0; j < 3; j++) pos_r[j] <= in_vec[j];
          OP_LOAD_VEL:  for (int j = 0; j < 3; j++) vel_r[j] <= in_vec[j];
          default: ;
        endcase
        sat_r <= sat_v;
      end

      if (phase_r) begin
        unique case (state_r)
          S_LOG: begin
            f_r <= {f_r[14:0], m_sq[31]};
            m_r <= m_sq[31] ? m_sq[31:1] : m_sq[30:0];
          end
          S_LT: begin
            e_r  <= e_new;
            ip_r <= e_new[20:16];
            if (e_new[35:16] > 20'd30) fac_r <= '0;
          end
          S_EXP: begin
            r_r <= r_new;
            if (k_r == 4'd15) fac_r <= fac_sum[30:14];
          end
          S_POS: begin
            rs = rnd_sat(prod, FRAC_BITS);
            as = add_sat(pos_r[vi], rs[VEC_W-1:0]);
            pos_r[vi] <= as[VEC_W-1:0];
            if (rs[VEC_W] || as[VEC_W]) sat_r <= 1'b1;
          end
          S_ACC: begin
            rs = rnd_sat(prod, FRAC_BITS);
            acc_r[vi] <= rs[VEC_W-1:0];
            if (rs[VEC_W]) sat_r <= 1'b1;
          end
          S_VEL: begin
            rs = rnd_sat(prod, FRAC_BITS);
            as = add_sat(vel_r[vi], rs[VEC_W-1:0]);
            vel_r[vi] <= as[VEC_W-1:0];
            if (rs[VEC_W] || as[VEC_W]) sat_r <= 1'b1;
          end
          S_DMP: begin
            rs = rnd_sat(prod, 16);
            vel_r[vi] <= rs[VEC_W-1:0];
            frc_r[vi] <= '0;
          end
          default: ;
        endcase
      end

      if (state_r == S_DONE && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
        out_sat_r   <= sat_r;
        out_data_r  <= {acc_r[2], acc_r[1], acc_r[0], vel_r[2], vel_r[1], vel_r[0],
                        pos_r[2], pos_r[1], pos_r[0]};
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

`ifndef NO_ASSERTIONS
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != S_IDLE)
    else $error("sequencer idle right after a request");

  a_norm_mantissa: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOG |-> m_r[30])
    else $error("log mantissa not normalized");

  a_fac_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DMP |-> fac_r <= 17'd65536)
    else $error("damping factor above one");

  a_forces_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && $past(state_r) == S_DMP) |->
      (frc_r[0] == '0 && frc_r[1] == '0 && frc_r[2] == '0))
    else $error("force sum not cleared after integrate");
`endif

endmodule

// ===== verif/tb.sv =====
// testbench for particle_euler_integrator: directed and random requests checked against a predictor
`timescale 1ns / 100ps

module tb;
  import pei_pkg::*;

  localparam int WDOG_LIMIT = 3000;
  localparam int DRAIN_WAIT = 120;

  typedef struct {
    logic [31:0] pos [3];
    logic [31:0] vel [3];
    logic [31:0] acc [3];
    logic        sat;
  } particle_state_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata = '0;   // vec_x, vec_y, vec_z, step_time, zero pad
  logic [2:0]   in_tuser = '0;   // opcode
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [287:0] out_tdata;       // pos_x..z, vel_x..z, acc_x..z
  logic [0:0]   out_tuser;       // saturated
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;

  // predicted particle state and register copies
  longint pos_s [3];
  longint vel_s [3];
  longint acc_s [3];
  longint frc_s [3];
  longint inv_mass_r;
  longint damping_r;
  bit     clip_seen;

  particle_state_t expected_q [$];
  int  errors = 0;
  bit  idle_on = 1'b1;
  int  hold_len = 0;
  int  quiet_cycles = 0;

  particle_euler_integrator DUT (.*);

  always #5 clk = ~clk;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) begin
      clip_seen = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip_seen = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // round to nearest, ties up
  function automatic longint round_shr(longint p, int s);
    return (p + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r + (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // damping raised to step time, Q1.16
  function automatic longint unsigned damp_power(longint unsigned d, longint unsigned t);
    int n;
    int ip;
    longint unsigned m, f, lg, e, r, c;
    if (d > 65536) d = 65536;
    if (t == 0 || d == 65536) return 65536;
    if (d == 0) return 0;
    n = 0;
    while ((d >> (n + 1)) != 0) n++;
    m = d << (30 - n);
    f = 0;
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd1 << 31)) begin
        f = f | 1;
        m = m >> 1;
      end
    end
    lg = (longint'(16 - n) << 16) - f;
    e = (lg * t) >> FRAC_BITS;
    if ((e >> 16) > 30) return 0;
    ip = int'(e >> 16);
    r = 64'd1 << 30;
    c = 64'd1 << 29;
    for (int k = 1; k <= 16; k++) begin
      c = int_sqrt(c << 30);
      if ((e >> (16 - k)) & 1) r = (r * c) >> 30;
    end
    return ((r >> ip) + 8192) >> 14;
  endfunction

  function automatic particle_state_t predict_particle(logic [2:0] op, logic [127:0] d);
    particle_state_t res;
    longint vin [3];
    longint st;
    longint fac;
    longint v;
    for (int i = 0; i < 3; i++) vin[i] = longint'($signed(d[32*i +: 32]));
    st = longint'(d[126:96]);
    clip_seen = 1'b0;
    case (op)
      OP_ADD_FORCE: for (int i = 0; i < 3; i++) frc_s[i] = clip32(frc_s[i] + vin[i]);
      OP_INTEGRATE: begin
        fac = longint'(damp_power(damping_r, st));
        for (int i = 0; i < 3; i++) begin
          pos_s[i] = clip32(pos_s[i] + clip32(round_shr(vel_s[i] * st, FRAC_BITS)));
          acc_s[i] = clip32(round_shr(frc_s[i] * inv_mass_r, FRAC_BITS));
          v = clip32(vel_s[i] + clip32(round_shr(acc_s[i] * st, FRAC_BITS)));
          vel_s[i] = round_shr(v * fac, 16);
          frc_s[i] = 0;
        end
      end
      OP_CLR_FORCE: for (int i = 0; i < 3; i++) frc_s[i] = 0;
      OP_LOAD_POS:  for (int i = 0; i < 3; i++) pos_s[i] = vin[i];
      OP_LOAD_VEL:  for (int i = 0; i < 3; i++) vel_s[i] = vin[i];
      default: ;
    endcase
    for (int i = 0; i < 3; i++) begin
      res.pos[i] = pos_s[i][31:0];
      res.vel[i] = vel_s[i][31:0];
      res.acc[i] = acc_s[i][31:0];
    end
    res.sat = clip_seen;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  task automatic send_request(logic [2:0] op, logic [31:0] x, logic [31:0] y,
                              logic [31:0] z, logic [30:0] st);
    logic [127:0] d;
    d = {1'b0, st, z, y, x};
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tuser  <= op;
    do @(posedge clk); while (!in_tready);
    expected_q.push_back(predict_particle(op, d));
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // wait for every result, then let the block settle before touching registers
  task automatic drain();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_INV_MASS) inv_mass_r = longint'(val[30:0]);
    else if (idx == REG_DAMPING) damping_r = longint'(val[16:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($urandom_range(0, 1 << 21)) - 32'd1048576;
      2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return 32'($urandom_range(0, 1 << 25)) - 32'd16777216;
    endcase
  endfunction

  function automatic logic [30:0] rand_step();
    case ($urandom_range(0, 9))
      0: return 31'($urandom());
      1: return '0;
      2: return 31'($urandom_range(1, 1 << 24));
      default: return 31'($urandom_range(1, 1 << 17));
    endcase
  endfunction

  // mostly force accumulation and integrates, with some stray requests
  task automatic random_requests(int count);
    int pick;
    logic [2:0] op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) op = OP_ADD_FORCE;
      else if (pick < 70) op = OP_INTEGRATE;
      else if (pick < 78) op = OP_CLR_FORCE;
      else if (pick < 86) op = OP_LOAD_POS;
      else if (pick < 94) op = OP_LOAD_VEL;
      else op = 3'($urandom_range(5, 7));
      send_request(op, rand_word(), rand_word(), rand_word(), rand_step());
    end
  endtask

  task automatic test_directed();
    send_request(OP_LOAD_POS, 32'h7fffffff, 32'h80000000, 32'h0, 31'd1);
    send_request(OP_LOAD_VEL, 32'h80000000, 32'h7fffffff, 32'h00010000, 31'd1);
    send_request(OP_INTEGRATE, '0, '0, '0, 31'h7fffffff);
    send_request(OP_ADD_FORCE, 32'h7fffffff, 32'h80000000, 32'h00020000, '0);
    send_request(OP_ADD_FORCE, 32'h7fffffff, 32'h80000000, 32'hffff0000, '0);
    send_request(OP_INTEGRATE, '0, '0, '0, 31'd1);
    send_request(OP_ADD_FORCE, 32'h00030000, 32'hfffd0000, 32'h00008000, '0);
    send_request(OP_CLR_FORCE, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
    send_request(OP_INTEGRATE, '0, '0, '0, '0);
    send_request(3'd5, 32'h12345678, 32'h0, 32'h0, 31'd5);
    send_request(3'd6, 32'h0, 32'h0, 32'h0, 31'd5);
    send_request(3'd7, 32'hffffffff, 32'hffffffff, 32'hffffffff, 31'h7fffffff);
    send_request(OP_LOAD_VEL, 32'h00100000, 32'hfff00000, 32'h00000001, '0);
    send_request(OP_ADD_FORCE, 32'h00010000, 32'h00010000, 32'h00010000, '0);
    send_request(OP_INTEGRATE, '0, '0, '0, 31'h00010000);
    drain();
    // immovable particle, damping above one
    write_reg(REG_INV_MASS, 32'h0);
    write_reg(REG_DAMPING, 32'h0001ffff);
    send_request(OP_ADD_FORCE, 32'h00050000, 32'h00050000, 32'h00050000, '0);
    send_request(OP_INTEGRATE, '0, '0, '0, 31'h00008000);
    drain();
    // no damping left at all
    write_reg(REG_DAMPING, 32'h0);
    send_request(OP_LOAD_VEL, 32'h00100000, 32'h00100000, 32'h00100000, '0);
    send_request(OP_INTEGRATE, '0, '0, '0, 31'h00010000);
    drain();
    // tiny damping with a long step drives the exponent past 30
    write_reg(REG_DAMPING, 32'h1);
    write_reg(REG_INV_MASS, 32'h7fffffff);
    send_request(OP_LOAD_VEL, 32'h00100000, 32'h00100000, 32'h00100000, '0);
    send_request(OP_ADD_FORCE, 32'h00000100, 32'hffffff00, 32'h00000001, '0);
    send_request(OP_INTEGRATE, '0, '0, '0, 31'h00100000);
    drain();
  endtask

  // receiver parked for a long stretch while requests keep coming
  task automatic test_backpressure();
    hold_len = 300;
    for (int n = 0; n < 8; n++)
      send_request(OP_ADD_FORCE, rand_word(), rand_word(), rand_word(), rand_step());
    send_request(OP_INTEGRATE, '0, '0, '0, 31'h00004000);
    drain();
  endtask

  task automatic test_random();
    write_reg(REG_INV_MASS, 32'h00010000);
    write_reg(REG_DAMPING, 32'h00010000);
    random_requests(350);
    drain();
    write_reg(REG_INV_MASS, 32'h0);
    write_reg(REG_DAMPING, 32'h0);
    random_requests(250);
    drain();
    write_reg(REG_INV_MASS, 32'h7fffffff);
    write_reg(REG_DAMPING, 32'h0001ffff);
    random_requests(250);
    drain();
    write_reg(REG_INV_MASS, $urandom_range(1, 1 << 18));
    write_reg(REG_DAMPING, $urandom_range(1, 65535));
    random_requests(350);
    drain();
    write_reg(REG_INV_MASS, $urandom());
    write_reg(REG_DAMPING, $urandom_range(60000, 65535));
    idle_on = 1'b0;
    random_requests(400);
    drain();
  endtask

  // receiver ready pattern
  initial begin
    forever begin
      if (hold_len > 0) begin
        out_tready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    particle_state_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result", out_tdata[31:0], '0);
      end else begin
        want = expected_q.pop_front();
        for (int i = 0; i < 3; i++) begin
          if (out_tdata[32*i +: 32] !== want.pos[i])
            report_mismatch($sformatf("pos[%0d]", i), out_tdata[32*i +: 32], want.pos[i]);
          if (out_tdata[96 + 32*i +: 32] !== want.vel[i])
            report_mismatch($sformatf("vel[%0d]", i), out_tdata[96 + 32*i +: 32],
                            want.vel[i]);
          if (out_tdata[192 + 32*i +: 32] !== want.acc[i])
            report_mismatch($sformatf("acc[%0d]", i), out_tdata[192 + 32*i +: 32],
                            want.acc[i]);
        end
        if (out_tuser[0] !== want.sat)
          report_mismatch("saturated", {31'b0, out_tuser[0]}, {31'b0, want.sat});
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("particle_euler_integrator test failed");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 3; i++) begin
      pos_s[i] = 0;
      vel_s[i] = 0;
      acc_s[i] = 0;
      frc_s[i] = 0;
    end
    inv_mass_r = 65536;
    damping_r = 65536;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    if (errors == 0)
      $display("particle_euler_integrator test passed");
    else
      $display("particle_euler_integrator test failed");
    $finish;
  end

endmodule
